// File: src/rkmi_pkg.sv
// Shared widths for the RSA key modular inverse block.
`timescale 1ns / 1ps
package rkmi_pkg;
    localparam int FACTOR_BITS = 31;
    localparam int WORD_BITS   = 62;
    localparam int CNT_BITS    = $clog2(WORD_BITS);
endpackage

// File: src/rsa_key_modular_inverse.sv
// Top level: modulus, totient and extended Euclid inverse of an exponent.
`timescale 1ns / 1ps
// One word in, one word out. The block forms n = p*q and t = (p-1)*(q-1)
// with one 31x31 multiplier, in S_MUL_N and then S_MUL_T, then runs extended
// Euclid on s and t. Each Euclid round is one shift-subtract division whose
// quotient bits feed a Horner accumulation of quo*x1 in the same cycles,
// plus an update (S_UPD) and a test (S_CHECK). The result word is registered
// in S_FIN once the remainder is zero, and o_ready stays low from acceptance
// until the result word is taken.
module rsa_key_modular_inverse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [30:0]                   i_factor_p,
    input  logic [30:0]                   i_factor_q,
    input  logic [rkmi_pkg::WORD_BITS-1:0] i_exponent_s,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rkmi_pkg::WORD_BITS-1:0] o_modulus_n,
    output logic [rkmi_pkg::WORD_BITS-1:0] o_totient_t,
    output logic [rkmi_pkg::WORD_BITS-1:0] o_gcd_value,
    output logic [rkmi_pkg::WORD_BITS-1:0] o_inverse_u,
    output logic                          o_coprime
);
    localparam int W  = rkmi_pkg::WORD_BITS;
    localparam int FB = rkmi_pkg::FACTOR_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_N, S_MUL_T, S_CHECK, S_DIV, S_UPD, S_FIN, S_DONE
    } t_state;

    t_state r_state;
    logic [FB-1:0] r_p, r_q;
    logic [W-1:0]  r_r0, r_r1, r_x0, r_x1, r_acc, r_t;
    logic [W:0]    r_rem;
    logic [rkmi_pkg::CNT_BITS-1:0] r_cnt;
    logic          r_odd;

    logic [FB-1:0]   w_ma, w_mb;
    logic [2*FB-1:0] w_prod;
    logic [W:0]      w_rem_sh, w_rem_sub;
    logic            w_bit;
    logic [W-1:0]    w_acc;
    logic [W-1:0]    w_m, w_u;
    logic            w_ok;

    always_comb begin
        w_ma = (r_state == S_MUL_N) ? r_p : ((r_p != '0) ? r_p - 1'b1 : '0);
        w_mb = (r_state == S_MUL_N) ? r_q : ((r_q != '0) ? r_q - 1'b1 : '0);
        w_prod = w_ma * w_mb;
        w_rem_sh  = {r_rem[W-1:0], r_r0[r_cnt]};
        w_bit     = (w_rem_sh >= {1'b0, r_r1});
        w_rem_sub = w_bit ? w_rem_sh - {1'b0, r_r1} : w_rem_sh;
        w_acc     = {r_acc[W-2:0], 1'b0} + (w_bit ? r_x1 : '0);
        w_ok      = (r_r0 == W'(1)) && (r_t != '0);
        w_m       = (r_x0 >= r_t) ? r_x0 - r_t : r_x0;
        w_u       = (r_odd && w_m != '0) ? r_t - w_m : w_m;
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_p     <= i_factor_p[FB-1:0];
                        r_q     <= i_factor_q[FB-1:0];
                        r_r0    <= i_exponent_s;
                        r_x0    <= W'(1);
                        r_x1    <= '0;
                        r_odd   <= 1'b0;
                        r_state <= S_MUL_N;
                    end
                end
                S_MUL_N: begin
                    o_modulus_n <= W'(w_prod);
                    r_state     <= S_MUL_T;
                end
                S_MUL_T: begin
                    r_t     <= W'(w_prod);
                    r_r1    <= W'(w_prod);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_rem <= '0;
                    r_acc <= '0;
                    r_cnt <= rkmi_pkg::CNT_BITS'(W - 1);
                    r_state <= (r_r1 == '0) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_rem_sub;
                    r_acc <= w_acc;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_UPD;
                end
                S_UPD: begin
                    r_r0    <= r_r1;
                    r_r1    <= r_rem[W-1:0];
                    r_x0    <= r_x1;
                    r_x1    <= r_x0 + r_acc;
                    r_odd   <= !r_odd;
                    r_state <= S_CHECK;
                end
                S_FIN: begin
                    o_totient_t <= r_t;
                    o_gcd_value <= r_r0;
                    o_coprime   <= w_ok;
                    o_inverse_u <= w_ok ? w_u : '0;
                    o_valid     <= 1'b1;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/rkmi_checker.sv
// Port-level checks for the RSA key modular inverse block, bound to the top.
`timescale 1ns / 1ps
module rkmi_assertions (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [rkmi_pkg::WORD_BITS-1:0] o_totient_t,
    input logic [rkmi_pkg::WORD_BITS-1:0] o_gcd_value,
    input logic [rkmi_pkg::WORD_BITS-1:0] o_inverse_u,
    input logic                          o_coprime
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_inverse_u) && $stable(o_gcd_value))
        else $error("result word changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while result pending");
    a_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_coprime |-> o_gcd_value == 1 && o_inverse_u < o_totient_t)
        else $error("coprime result inconsistent");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_coprime |-> o_inverse_u == 0)
        else $error("inverse nonzero without coprime");
endmodule

bind rsa_key_modular_inverse rkmi_assertions u_rkmi_assertions (.*);

// File: test/rkmi_checker.sv
// Checker: watches both channels, predicts each result word and compares.
`timescale 1ns / 1ps
module rkmi_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_ready,
    input  logic [30:0]                     i_factor_p,
    input  logic [30:0]                     i_factor_q,
    input  logic [rkmi_pkg::WORD_BITS-1:0]  i_exponent_s,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  logic [rkmi_pkg::WORD_BITS-1:0]  o_modulus_n,
    input  logic [rkmi_pkg::WORD_BITS-1:0]  o_totient_t,
    input  logic [rkmi_pkg::WORD_BITS-1:0]  o_gcd_value,
    input  logic [rkmi_pkg::WORD_BITS-1:0]  o_inverse_u,
    input  logic                            o_coprime,
    output int                              o_errors,
    output int                              o_pending
);
    typedef logic [rkmi_pkg::WORD_BITS-1:0] t_word;

    typedef struct packed {
        t_word n;
        t_word t;
        t_word g;
        t_word u;
        logic  c;
    } t_key_result;

    t_key_result key_q[$];

    function automatic t_key_result predict_key(logic [30:0] p_in, logic [30:0] q_in,
                                                t_word s);
        t_key_result res;
        logic [63:0] p, q, pm, qm, t, r0, r1, x0, x1, quo, rn, xn, m;
        logic odd;
        p = 64'(p_in[rkmi_pkg::FACTOR_BITS-1:0]);
        q = 64'(q_in[rkmi_pkg::FACTOR_BITS-1:0]);
        pm = (p != 0) ? p - 1 : 0;
        qm = (q != 0) ? q - 1 : 0;
        t = (pm * qm) & {2'b00, {62{1'b1}}};
        res.n = t_word'(p * q);
        res.t = t_word'(t);
        r0 = 64'(s);
        r1 = t;
        x0 = 1;
        x1 = 0;
        odd = 1'b0;
        while (r1 != 0) begin
            quo = r0 / r1;
            rn = r0 - quo * r1;
            xn = x0 + quo * x1;
            r0 = r1;
            r1 = rn;
            x0 = x1;
            x1 = xn;
            odd = ~odd;
        end
        res.g = t_word'(r0);
        res.c = (r0 == 1) && (t != 0);
        res.u = '0;
        if (res.c) begin
            m = x0 % t;
            if (odd && m != 0)
                m = t - m;
            res.u = t_word'(m);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, t_word got, t_word want);
        $display("mismatch %s: got %h want %h", what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        t_key_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                key_q.push_back(predict_key(i_factor_p, i_factor_q, i_exponent_s));
            if (o_valid && i_ready) begin
                if (key_q.size() == 0) begin
                    report_mismatch("unexpected word", o_modulus_n, '0);
                end else begin
                    want = key_q.pop_front();
                    if (o_modulus_n !== want.n) report_mismatch("modulus_n", o_modulus_n, want.n);
                    if (o_totient_t !== want.t) report_mismatch("totient_t", o_totient_t, want.t);
                    if (o_gcd_value !== want.g) report_mismatch("gcd_value", o_gcd_value, want.g);
                    if (o_inverse_u !== want.u) report_mismatch("inverse_u", o_inverse_u, want.u);
                    if (o_coprime !== want.c)
                        report_mismatch("coprime", t_word'(o_coprime), t_word'(want.c));
                end
            end
        end
        o_pending = key_q.size();
    end
endmodule

// File: test/tb.sv
// Testbench top: clock, reset, stimulus with random idling, and verdict.
`timescale 1ns / 1ps
module tb;
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [30:0]                    i_factor_p = '0;
    logic [30:0]                    i_factor_q = '0;
    logic [rkmi_pkg::WORD_BITS-1:0] i_exponent_s = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [rkmi_pkg::WORD_BITS-1:0] o_modulus_n, o_totient_t, o_gcd_value, o_inverse_u;
    logic                           o_coprime;
    int                             errors, pending;
    longint                         cycles = 0;
    bit                             calm = 1'b0;

    localparam longint CYCLE_LIMIT = 40_000_000;

    always #6 i_clk = ~i_clk;

    rsa_key_modular_inverse DUT (.*);

    rkmi_checker u_checker (.*, .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);

    function automatic logic [30:0] rand_prime_ish();
        logic [30:0] v;
        case ($urandom_range(3))
            0: v = 31'($urandom_range(255, 2));
            1: v = 31'($urandom_range(65535, 2)) | 31'd1;
            default: v = 31'($urandom) | 31'd1;
        endcase
        return v;
    endfunction

    function automatic logic [rkmi_pkg::WORD_BITS-1:0] rand_exp();
        logic [rkmi_pkg::WORD_BITS-1:0] v;
        case ($urandom_range(3))
            0: v = rkmi_pkg::WORD_BITS'($urandom_range(70000));
            1: v = rkmi_pkg::WORD_BITS'({$urandom, $urandom}) | 62'd1;
            2: v = rkmi_pkg::WORD_BITS'(65537);
            default: v = rkmi_pkg::WORD_BITS'({$urandom, $urandom});
        endcase
        return v;
    endfunction

    task automatic send_word(logic [30:0] p, logic [30:0] q,
                             logic [rkmi_pkg::WORD_BITS-1:0] s);
        while (!calm && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_factor_p <= p;
        i_factor_q <= q;
        i_exponent_s <= s;
        i_valid <= 1'b1;
        while (!o_ready)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_word(31'd61, 31'd53, 62'd17);
        send_word(31'd0, 31'd7, 62'd5);
        send_word(31'd1, 31'd7, 62'd5);
        send_word(31'd2, 31'd2, 62'd9);
        send_word(31'd11, 31'd13, 62'd0);
        send_word(31'd0, 31'd0, 62'd0);
        send_word(31'd1, 31'd2, 62'd0);
        send_word(31'd2, 31'd3, 62'd1);
        send_word(31'd3, 31'd2, 62'd0);
        send_word(31'd61, 31'd53, 62'd100017);
        send_word(31'd11, 31'd13, 62'd6);
        send_word('1, '1, '1);
        send_word('1, '1, 62'd65537);
        send_word(31'd2147483629, 31'd2147483587, 62'd65537);
        send_word('1, 31'd2, '1);
        send_word(31'h55555555, 31'h2aaaaaaa, 62'h2aaaaaaaaaaaaaaa);
        send_word(31'h2aaaaaaa, 31'h55555555, 62'h1555555555555555);
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        calm = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(rand_prime_ish(), rand_prime_ish(), rand_exp());
        calm = 1'b0;
        for (int i = 0; i < 70; i++)
            send_word(rand_prime_ish(), rand_prime_ish(), rand_exp());
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
